FILE: hw/rtl/colour_sensor_frame_parser_defines.svh
// assertion macros shared by the colour sensor frame parser modules
`ifndef COLOUR_SENSOR_FRAME_PARSER_DEFINES_SVH
`define COLOUR_SENSOR_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define CSFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csfp same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define CSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csfp next-cycle check failed");
`else
`define CSFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define CSFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/csfp_pkg.sv
// types, constants and helpers for the colour sensor frame parser
package csfp_pkg;

   // frame framing bytes
   localparam logic [7:0] HDR_BYTE  = 8'h5A;
   localparam logic [7:0] TYPE_RGBC = 8'h15;
   localparam logic [7:0] TYPE_LCC  = 8'h25;
   localparam logic [7:0] TYPE_RGB  = 8'h45;

   // frame lengths in bytes, checksum included
   localparam logic [3:0] LEN_RGBC     = 4'd13;
   localparam logic [3:0] LEN_LCC      = 4'd11;
   localparam logic [3:0] LEN_RGB      = 4'd8;
   localparam logic [3:0] NO_FMT_LIMIT = 4'd13;

   // count values with a fixed role
   localparam logic [3:0] CNT_HDR0    = 4'd0;
   localparam logic [3:0] CNT_HDR1    = 4'd1;
   localparam logic [3:0] CNT_TYPE    = 4'd2;
   localparam logic [3:0] CNT_MAX     = 4'd12;
   localparam int         DATA_FIRST  = 4;
   localparam int         DATA_BYTES  = 8;

   typedef enum logic [1:0] {
      FMT_RGBC = 2'd0,
      FMT_LCC  = 2'd1,
      FMT_RGB  = 2'd2,
      FMT_NONE = 2'd3
   } fmt_type;

   // frame status handed from the tracker to the value store
   typedef struct packed {
      logic                            emit;
      logic                            good;
      fmt_type                         fmt;
      logic [DATA_BYTES-1:0][7:0]      data;
   } track_type;

   typedef logic [3:0][15:0] vals_type;

   function automatic logic [3:0] frame_len(input fmt_type fmt);
      logic [3:0] len;
      unique case (fmt)
         FMT_RGBC: len = LEN_RGBC;
         FMT_LCC:  len = LEN_LCC;
         FMT_RGB:  len = LEN_RGB;
         FMT_NONE: len = NO_FMT_LIMIT;
      endcase
      return len;
   endfunction

endpackage

FILE: hw/rtl/colour_sensor_frame_parser.sv
// Colour sensor frame parser top level: byte tracking, value store, result register.
// A result is valid in the cycle after the transfer of a frame's checksum byte.
// Throughput: one byte per cycle while req_stall is low; each byte passes once through the byte tracker.
// Bytes that end no frame are taken even while a result waits in the output register.
// Reset (synchronous): byte count 0, no format, held values zero, no result pending.
`include "colour_sensor_frame_parser_defines.svh"

module colour_sensor_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_format,
   output logic        rsp_checksum_good,
   output logic [15:0] rsp_value_0,
   output logic [15:0] rsp_value_1,
   output logic [15:0] rsp_value_2,
   output logic [15:0] rsp_value_3
);

   csfp_pkg::track_type track;
   csfp_pkg::vals_type  vals;
   logic                take, load;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          fmt_ff;
   logic                good_ff;
   csfp_pkg::vals_type  vals_ff;

   // hold only a frame-ending byte while the result register is blocked
   assign req_stall = track.emit && rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;
   assign load      = take && track.emit;

   csfp_frame_track u_track (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .track   (track)
   );

   csfp_value_hold u_hold (
      .clock  (clock),
      .reset  (reset),
      .update (load && track.good),
      .track  (track),
      .vals   (vals)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fmt_ff  <= 2'(track.fmt);
         good_ff <= track.good;
         vals_ff <= vals;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_format  = fmt_ff;
   assign rsp_checksum_good = good_ff;
   assign rsp_value_0       = vals_ff[0];
   assign rsp_value_1       = vals_ff[1];
   assign rsp_value_2       = vals_ff[2];
   assign rsp_value_3       = vals_ff[3];

   `CSFP_ASSERT_SAME(a_no_overrun, clock, reset, load, !rsp_valid_ff || !rsp_stall)
   `CSFP_ASSERT_SAME(a_format_known, clock, reset, rsp_valid_ff,
                     fmt_ff != 2'(csfp_pkg::FMT_NONE))
   `CSFP_ASSERT_SAME(a_clear_only_rgbc, clock, reset,
                     rsp_valid_ff && (fmt_ff != 2'(csfp_pkg::FMT_RGBC)), vals_ff[3] == 16'd0)

endmodule

FILE: hw/rtl/csfp_frame_track.sv
// byte counter, header and type decode, running checksum and payload byte store
`include "colour_sensor_frame_parser_defines.svh"

module csfp_frame_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output csfp_pkg::track_type  track
);

   logic [3:0]        count_ff, count_in, cnt_inc;
   csfp_pkg::fmt_type fmt_ff, fmt_in;
   logic [7:0]        sum_ff, sum_in;
   logic              hdr0_ok_ff, hdr0_ok_in;
   logic [csfp_pkg::DATA_BYTES-1:0][7:0] data_ff;
   logic              emit, hdr_fail, none_wrap;

   assign cnt_inc = count_ff + 4'd1;

   // format decode on the type byte
   always_comb begin
      fmt_in = fmt_ff;
      if (count_ff == csfp_pkg::CNT_TYPE) begin
         unique case (rx_byte)
            csfp_pkg::TYPE_RGBC: fmt_in = csfp_pkg::FMT_RGBC;
            csfp_pkg::TYPE_LCC:  fmt_in = csfp_pkg::FMT_LCC;
            csfp_pkg::TYPE_RGB:  fmt_in = csfp_pkg::FMT_RGB;
            default:             fmt_in = fmt_ff;
         endcase
      end
   end

   // frame end, header check and count restart
   always_comb begin
      hdr0_ok_in = hdr0_ok_ff;
      if (count_ff == csfp_pkg::CNT_HDR0) begin
         hdr0_ok_in = (rx_byte == csfp_pkg::HDR_BYTE);
      end
      hdr_fail  = (count_ff == csfp_pkg::CNT_HDR1) &&
                  !(hdr0_ok_ff && (rx_byte == csfp_pkg::HDR_BYTE));
      emit      = (fmt_ff != csfp_pkg::FMT_NONE) &&
                  (cnt_inc == csfp_pkg::frame_len(fmt_ff));
      none_wrap = (fmt_in == csfp_pkg::FMT_NONE) && (cnt_inc == csfp_pkg::NO_FMT_LIMIT);
      count_in  = (emit || hdr_fail || none_wrap) ? 4'd0 : cnt_inc;
      sum_in    = (count_in == 4'd0) ? 8'd0 : sum_ff + rx_byte;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 4'd0;
         fmt_ff     <= csfp_pkg::FMT_NONE;
         sum_ff     <= 8'd0;
         hdr0_ok_ff <= 1'b0;
      end else if (take) begin
         count_ff   <= count_in;
         fmt_ff     <= fmt_in;
         sum_ff     <= sum_in;
         hdr0_ok_ff <= hdr0_ok_in;
      end
   end

   // payload bytes, each entry written at its own count
   always_ff @(posedge clock) begin
      for (int i = 0; i < csfp_pkg::DATA_BYTES; i++) begin
         if (take && (count_ff == 4'(i + csfp_pkg::DATA_FIRST))) begin
            data_ff[i] <= rx_byte;
         end
      end
   end

   assign track.emit = emit;
   assign track.good = (sum_ff == rx_byte);
   assign track.fmt  = fmt_ff;
   assign track.data = data_ff;

   `CSFP_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= csfp_pkg::CNT_MAX)
   `CSFP_ASSERT_SAME(a_no_emit_unformatted, clock, reset, fmt_ff == csfp_pkg::FMT_NONE, !emit)
   `CSFP_ASSERT_NEXT(a_restart_after_end, clock, reset, take && emit,
                     (count_ff == 4'd0) && (sum_ff == 8'd0))

endmodule

FILE: hw/rtl/csfp_value_hold.sv
// held measurement values per format and the value selection for a result
module csfp_value_hold (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  csfp_pkg::track_type  track,
   output csfp_pkg::vals_type   vals
);

   logic [3:0][15:0] rgbc_ff, rgbc_in;
   logic [2:0][15:0] lcc_ff, lcc_in;
   logic [2:0][7:0]  rgb_ff, rgb_in;
   logic [3:0][15:0] words;

   // big-endian words from the payload bytes
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         words[i] = {track.data[2 * i], track.data[2 * i + 1]};
      end
   end

   // next held values on a passing frame
   always_comb begin
      rgbc_in = rgbc_ff;
      lcc_in  = lcc_ff;
      rgb_in  = rgb_ff;
      if (update) begin
         unique case (track.fmt)
            csfp_pkg::FMT_RGBC: rgbc_in = words;
            csfp_pkg::FMT_LCC:  lcc_in  = words[2:0];
            csfp_pkg::FMT_RGB:  rgb_in  = track.data[2:0];
            csfp_pkg::FMT_NONE: rgb_in  = rgb_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rgbc_ff <= '0;
         lcc_ff  <= '0;
         rgb_ff  <= '0;
      end else begin
         rgbc_ff <= rgbc_in;
         lcc_ff  <= lcc_in;
         rgb_ff  <= rgb_in;
      end
   end

   // values of the frame's format after the update
   always_comb begin
      unique case (track.fmt)
         csfp_pkg::FMT_RGBC: vals = rgbc_in;
         csfp_pkg::FMT_LCC:  vals = {16'd0, lcc_in};
         csfp_pkg::FMT_RGB:  vals = {16'd0, {8'd0, rgb_in[2]}, {8'd0, rgb_in[1]},
                                     {8'd0, rgb_in[0]}};
         csfp_pkg::FMT_NONE: vals = '0;
      endcase
   end

endmodule
